### hdl/hbds_pkg.sv
package hbds_pkg;

   // Fixed field widths
   localparam int unsigned CHAR_WIDTH = 8;
   localparam int unsigned HASH_WIDTH = 8;
   localparam int unsigned SET_BITS   = 256;
   localparam int unsigned OUT_WIDTH  = 16;
   localparam int unsigned QUO_BITS   = 16;

   // Defaults for the top-level parameters
   localparam int unsigned COUNT_WIDTH_DEFAULT = 16;
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   // ASCII lower-case range and case offset
   localparam logic [CHAR_WIDTH-1:0] LOWER_FIRST = 8'h61;
   localparam logic [CHAR_WIDTH-1:0] LOWER_LAST  = 8'h7A;
   localparam logic [CHAR_WIDTH-1:0] CASE_OFFSET = 8'h20;

   typedef enum logic [1:0] {
      ACT_ORIGIN  = 2'd0,
      ACT_COMPARE = 2'd1,
      ACT_FINISH  = 2'd2
   } action_type;

   typedef enum logic {
      CMD_PAIRS,
      CMD_FINISH
   } cmd_kind_type;

   // One queued command: up to two pairs of one character, or a finish.
   typedef struct packed {
      cmd_kind_type          kind;
      logic                  is_compare;
      logic                  pair_valid;
      logic [HASH_WIDTH-1:0] hash;
      logic                  term_valid;
   } cmd_type;

   typedef enum logic {
      BK_IDLE,
      BK_DIVIDE
   } back_state_type;

endpackage

### hdl/hbds_if.sv
interface hbds_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          action;
   logic [hbds_pkg::CHAR_WIDTH-1:0]     char_byte;
   logic                                last_char;

   modport source (output valid, action, char_byte, last_char, input ready);
   modport sink   (input valid, action, char_byte, last_char, output ready);
endinterface

interface hbds_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [hbds_pkg::OUT_WIDTH-1:0]      similarity_q14;
   logic [hbds_pkg::OUT_WIDTH-1:0]      common_pairs;
   logic [hbds_pkg::OUT_WIDTH-1:0]      total_pairs;

   modport source (output valid, similarity_q14, common_pairs, total_pairs, input ready);
   modport sink   (input valid, similarity_q14, common_pairs, total_pairs, output ready);
endinterface

### hdl/hbds_front.sv
module hbds_front (
   input  logic               clock,
   input  logic               reset,
   hbds_req_if.sink           req,
   input  logic               q_full,
   output logic               q_push,
   output hbds_pkg::cmd_type  q_data
);

   logic [hbds_pkg::CHAR_WIDTH-1:0]   prev_ff, prev_in;
   logic                              have_prev_ff, have_prev_in;
   logic [hbds_pkg::CHAR_WIDTH-1:0]   up_char;
   logic [2*hbds_pkg::CHAR_WIDTH-1:0] product;
   logic                              accept;

   assign req.ready = !q_full;
   assign accept    = req.valid && !q_full;

   always_comb begin
      up_char = req.char_byte;
      if (req.char_byte >= hbds_pkg::LOWER_FIRST && req.char_byte <= hbds_pkg::LOWER_LAST) begin
         up_char = req.char_byte - hbds_pkg::CASE_OFFSET;
      end
   end

   assign product = (2*hbds_pkg::CHAR_WIDTH)'(prev_ff) * (2*hbds_pkg::CHAR_WIDTH)'(up_char);

   always_comb begin
      prev_in           = prev_ff;
      have_prev_in      = have_prev_ff;
      q_push            = 1'b0;
      q_data.kind       = hbds_pkg::CMD_PAIRS;
      q_data.is_compare = (req.action == hbds_pkg::ACT_COMPARE);
      q_data.pair_valid = have_prev_ff;
      q_data.hash       = product[hbds_pkg::HASH_WIDTH-1:0];
      q_data.term_valid = req.last_char;
      unique case (hbds_pkg::action_type'(req.action))
         hbds_pkg::ACT_ORIGIN, hbds_pkg::ACT_COMPARE: begin
            q_push = accept;
            if (accept) begin
               // The terminator pair closes the string; otherwise the
               // character waits for its partner.
               prev_in      = req.last_char ? '0 : up_char;
               have_prev_in = !req.last_char;
            end
         end
         hbds_pkg::ACT_FINISH: begin
            q_push      = accept;
            q_data.kind = hbds_pkg::CMD_FINISH;
            if (accept) begin
               prev_in      = '0;
               have_prev_in = 1'b0;
            end
         end
         default: begin
            q_push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
      end else begin
         prev_ff      <= prev_in;
         have_prev_ff <= have_prev_in;
      end
   end

endmodule

### hdl/hbds_fifo.sv
module hbds_fifo #(
   parameter int unsigned DEPTH = hbds_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  hbds_pkg::cmd_type  push_data,
   input  logic               pop,
   output hbds_pkg::cmd_type  head_data,
   output logic               full,
   output logic               empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   hbds_pkg::cmd_type  mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hdl/hbds_div.sv
module hbds_div #(
   parameter int unsigned COUNT_WIDTH = hbds_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [COUNT_WIDTH-1:0]            dividend,
   input  logic [COUNT_WIDTH-1:0]            divisor,
   output logic                              done,
   output logic [hbds_pkg::QUO_BITS-1:0]     quotient
);

   localparam int unsigned STEP_W = $clog2(hbds_pkg::QUO_BITS + 1);

   // Restoring division of dividend * 2^(QUO_BITS-1) by divisor, one
   // quotient bit per cycle. The dividend never exceeds the divisor, so the
   // remainder fits in one bit more than the counters.
   logic [COUNT_WIDTH:0]              rem_ff, rem_in;
   logic [COUNT_WIDTH-1:0]            div_ff, div_in;
   logic [hbds_pkg::QUO_BITS-1:0]     quo_ff, quo_in;
   logic [STEP_W-1:0]                 step_ff, step_in;
   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [COUNT_WIDTH:0]              diff;
   logic                              fits;

   assign diff     = rem_ff - {1'b0, div_ff};
   assign fits     = (rem_ff >= {1'b0, div_ff});
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = {1'b0, dividend};
         div_in  = divisor;
         quo_in  = '0;
         step_in = STEP_W'(hbds_pkg::QUO_BITS);
         busy_in = (divisor != '0);
         done_in = (divisor == '0);
      end else if (busy_ff) begin
         quo_in  = {quo_ff[hbds_pkg::QUO_BITS-2:0], fits};
         rem_in  = fits ? {diff[COUNT_WIDTH-1:0], 1'b0} : {rem_ff[COUNT_WIDTH-1:0], 1'b0};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

endmodule

### hdl/hbds_back.sv
module hbds_back #(
   parameter int unsigned COUNT_WIDTH = hbds_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  hbds_pkg::cmd_type  q_head,
   output logic               q_pop,
   hbds_rsp_if.source         rsp
);

   hbds_pkg::back_state_type          state_ff, state_in;
   logic [hbds_pkg::SET_BITS-1:0]     set_ff, set_in;
   logic [COUNT_WIDTH-1:0]            common_ff, common_in;
   logic [COUNT_WIDTH-1:0]            total_ff, total_in;
   logic                              rsp_valid_ff;
   logic [hbds_pkg::OUT_WIDTH-1:0]    sim_ff, common_out_ff, total_out_ff;
   logic [hbds_pkg::OUT_WIDTH-1:0]    common_sat, total_sat;
   logic                              out_free;
   logic                              do_pairs;
   logic                              div_start;
   logic                              load_out;
   logic                              div_done;
   logic [hbds_pkg::QUO_BITS-1:0]     div_quo;
   logic                              hit_pair, hit_term;
   logic [1:0]                        inc_total, inc_common;
   logic [COUNT_WIDTH:0]              total_sum, common_sum;

   assign out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in  = state_ff;
      q_pop     = 1'b0;
      do_pairs  = 1'b0;
      div_start = 1'b0;
      load_out  = 1'b0;
      unique case (state_ff)
         hbds_pkg::BK_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (q_head.kind == hbds_pkg::CMD_FINISH) begin
                  div_start = 1'b1;
                  state_in  = hbds_pkg::BK_DIVIDE;
               end else begin
                  do_pairs = 1'b1;
               end
            end
         end
         hbds_pkg::BK_DIVIDE: begin
            if (div_done && out_free) begin
               load_out = 1'b1;
               state_in = hbds_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = hbds_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hbds_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Pair lookup and set update. The terminator pair always hashes to zero.
   assign hit_pair   = q_head.pair_valid && set_ff[q_head.hash];
   assign hit_term   = q_head.term_valid && set_ff[0];
   assign inc_total  = {1'b0, q_head.pair_valid} + {1'b0, q_head.term_valid};
   assign inc_common = q_head.is_compare ? ({1'b0, hit_pair} + {1'b0, hit_term}) : 2'd0;
   assign total_sum  = {1'b0, total_ff} + (COUNT_WIDTH + 1)'(inc_total);
   assign common_sum = {1'b0, common_ff} + (COUNT_WIDTH + 1)'(inc_common);

   always_comb begin
      set_in    = set_ff;
      total_in  = total_ff;
      common_in = common_ff;
      if (load_out) begin
         set_in    = '0;
         total_in  = '0;
         common_in = '0;
      end else if (do_pairs) begin
         if (!q_head.is_compare) begin
            if (q_head.pair_valid) begin
               set_in[q_head.hash] = 1'b1;
            end
            if (q_head.term_valid) begin
               set_in[0] = 1'b1;
            end
         end
         total_in  = total_sum[COUNT_WIDTH]  ? '1 : total_sum[COUNT_WIDTH-1:0];
         common_in = common_sum[COUNT_WIDTH] ? '1 : common_sum[COUNT_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_ff       <= '0;
         total_ff     <= '0;
         common_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         set_ff    <= set_in;
         total_ff  <= total_in;
         common_ff <= common_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   hbds_div #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (common_ff),
      .divisor  (total_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   generate
      if (COUNT_WIDTH > hbds_pkg::OUT_WIDTH) begin : g_out_sat
         assign common_sat = (|common_ff[COUNT_WIDTH-1:hbds_pkg::OUT_WIDTH]) ?
                             '1 : common_ff[hbds_pkg::OUT_WIDTH-1:0];
         assign total_sat  = (|total_ff[COUNT_WIDTH-1:hbds_pkg::OUT_WIDTH]) ?
                             '1 : total_ff[hbds_pkg::OUT_WIDTH-1:0];
      end else begin : g_out_ext
         assign common_sat = hbds_pkg::OUT_WIDTH'(common_ff);
         assign total_sat  = hbds_pkg::OUT_WIDTH'(total_ff);
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (load_out) begin
         sim_ff        <= div_quo;
         common_out_ff <= common_sat;
         total_out_ff  <= total_sat;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.similarity_q14 = sim_ff;
   assign rsp.common_pairs   = common_out_ff;
   assign rsp.total_pairs    = total_out_ff;

endmodule

### hdl/hashed_bigram_dice_similarity.sv
// Hashed bigram Dice similarity. Characters: one transfer per cycle while the queue has room.
// A character is written into the queue on its transfer and reaches the pair set when the
// back end pops it. A popped finish starts the divider, which gives zero if no pair was seen.
// While a finish divides, the back end stalls and the front keeps filling the queue.
// Reset (synchronous, active high) clears the pair set, counters, pending character,
// queue and result valid flag; no clearing pass is needed.
module hashed_bigram_dice_similarity #(
   parameter int unsigned COUNT_WIDTH = hbds_pkg::COUNT_WIDTH_DEFAULT,
   parameter int unsigned QUEUE_DEPTH = hbds_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   hbds_req_if.sink    req_ch,
   hbds_rsp_if.source  rsp_ch
);

   // The front end upper-cases each character, keeps the pending character of the
   // current string and hashes each pair as the low byte of the product. An origin,
   // compare or finish transfer becomes one command: the pair with the pending
   // character and any terminator pair, or a finish that drops the pending character.
   hbds_pkg::cmd_type  q_push_data;
   hbds_pkg::cmd_type  q_head;
   logic               q_push;
   logic               q_pop;
   logic               q_full;
   logic               q_empty;

   hbds_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_data (q_push_data)
   );

   // A short queue lets characters keep streaming while the back end divides.
   hbds_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head_data (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   // The back end owns the 256-bit pair set and the saturating counters. Origin
   // pairs set their bit; compare pairs count as common where their bit is set.
   // A finish starts the divider; once it is done and the output register is
   // free, the result is loaded and the pair set and counters return to zero.
   hbds_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp     (rsp_ch)
   );

`ifndef NO_ASSERTIONS
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("command pushed into a full queue");

   a_pop_has_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("command popped from an empty queue");

   a_result_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.common_pairs <= rsp_ch.total_pairs) &&
                       (rsp_ch.similarity_q14 <= 16'd32768))
      else $error("result has common above total or a ratio above two");
`endif

endmodule
